// File: hdl/hq_pkg.sv
package hq_pkg;

    localparam int ANGLE_BITS      = 16;
    localparam int OUT_BITS        = 16;

    // Rotation CORDIC
    localparam int CORDIC_STEPS    = 28;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
    // quadrant fold stage + rotation stages + quadrant map stage
    localparam int CORDIC_LAT      = CORDIC_STAGES + 2;

    localparam int PHASE_W = 32;
    localparam int XY_W    = 34;
    localparam int Z_W     = 32;
    localparam int CS_W    = 32;
    localparam int PROD_W  = 2 * CS_W;

    localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032874);

    // phase register, then CORDIC, then product, then round and saturate
    localparam int PIPE_LEN = 1 + CORDIC_LAT + 2;

    typedef logic [ANGLE_BITS-1:0]      angle_t;
    typedef logic [ANGLE_BITS:0]        half_angle_t;
    typedef logic signed [CS_W-1:0]     trig_t;
    typedef logic signed [OUT_BITS-1:0] quat_part_t;

    // arctangent of 2^-i in 2^32 units per turn
    function automatic logic [Z_W-1:0] atan_turn(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:  v = Z_W'(536870912);
            1:  v = Z_W'(316933406);
            2:  v = Z_W'(167458907);
            3:  v = Z_W'(85004756);
            4:  v = Z_W'(42667331);
            5:  v = Z_W'(21354465);
            6:  v = Z_W'(10679838);
            7:  v = Z_W'(5340245);
            8:  v = Z_W'(2670163);
            9:  v = Z_W'(1335087);
            10: v = Z_W'(667544);
            11: v = Z_W'(333772);
            12: v = Z_W'(166886);
            13: v = Z_W'(83443);
            14: v = Z_W'(41722);
            15: v = Z_W'(20861);
            16: v = Z_W'(10430);
            17: v = Z_W'(5215);
            18: v = Z_W'(2608);
            19: v = Z_W'(1304);
            20: v = Z_W'(652);
            21: v = Z_W'(326);
            22: v = Z_W'(163);
            23: v = Z_W'(81);
            24: v = Z_W'(41);
            25: v = Z_W'(20);
            26: v = Z_W'(10);
            27: v = Z_W'(5);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/hq_sample_if.sv
interface hq_sample_if;
    logic               valid;
    logic               ready;
    hq_pkg::angle_t     theta;
    hq_pkg::angle_t     phi;
    hq_pkg::angle_t     psi;

    modport source (output valid, output theta, output phi, output psi, input ready);
    modport sink   (input valid, input theta, input phi, input psi, output ready);
endinterface

// File: hdl/hq_quat_if.sv
interface hq_quat_if;
    logic               valid;
    logic               ready;
    hq_pkg::quat_part_t quat_w;
    hq_pkg::quat_part_t quat_x;
    hq_pkg::quat_part_t quat_y;
    hq_pkg::quat_part_t quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

// File: hdl/hq_cordic.sv
// Pipelined sine/cosine of a half-angle phase, Q2.30 results.
module hq_cordic (
    input  logic                clk,
    input  logic                en,
    input  hq_pkg::half_angle_t phase,
    output hq_pkg::trig_t       cos_val,
    output hq_pkg::trig_t       sin_val
);

    localparam int NS  = hq_pkg::CORDIC_STAGES;
    localparam int SPS = hq_pkg::STEPS_PER_STAGE;
    localparam int XW  = hq_pkg::XY_W;
    localparam int ZW  = hq_pkg::Z_W;
    localparam int PW  = hq_pkg::PHASE_W;
    localparam int PAD = PW - (hq_pkg::ANGLE_BITS + 1);

    logic signed [XW-1:0] x_reg [NS+1];
    logic signed [XW-1:0] y_reg [NS+1];
    logic signed [ZW-1:0] z_reg [NS+1];
    logic [1:0]           q_reg [NS+1];

    logic signed [XW-1:0] x_next [NS];
    logic signed [XW-1:0] y_next [NS];
    logic signed [ZW-1:0] z_next [NS];

    logic [PW-1:0]        ph_full;
    logic [PW-1:0]        ph_bias;
    logic [1:0]           q0_next;
    logic [PW-1:0]        z0_next;

    hq_pkg::trig_t        cos_reg;
    hq_pkg::trig_t        sin_reg;
    hq_pkg::trig_t        cos_next;
    hq_pkg::trig_t        sin_next;

    // fold to the nearest quadrant, residual within a quarter turn
    always_comb
    begin
        ph_full = {phase, {PAD{1'b0}}};
        ph_bias = ph_full + {2'b00, 1'b1, {(PW-3){1'b0}}};
        q0_next = ph_bias[PW-1:PW-2];
        z0_next = ph_full - {q0_next, {(PW-2){1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= hq_pkg::CORDIC_X0;
            y_reg[0] <= '0;
            z_reg[0] <= ZW'(signed'(z0_next));
            q_reg[0] <= q0_next;
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic signed [XW-1:0] xt;
        logic signed [XW-1:0] yt;
        logic signed [ZW-1:0] zt;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;

        always_comb
        begin
            xt = x_reg[s];
            yt = y_reg[s];
            zt = z_reg[s];
            dx = '0;
            dy = '0;
            for (int k = 0; k < SPS; k++)
            begin
                dx = yt >>> (s * SPS + k);
                dy = xt >>> (s * SPS + k);
                if (!zt[ZW-1])
                begin
                    xt = xt - dx;
                    yt = yt + dy;
                    zt = zt - signed'(hq_pkg::atan_turn(s * SPS + k));
                end
                else
                begin
                    xt = xt + dx;
                    yt = yt - dy;
                    zt = zt + signed'(hq_pkg::atan_turn(s * SPS + k));
                end
            end
            x_next[s] = xt;
            y_next[s] = yt;
            z_next[s] = zt;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s+1] <= x_next[s];
                y_reg[s+1] <= y_next[s];
                z_reg[s+1] <= z_next[s];
                q_reg[s+1] <= q_reg[s];
            end
        end
    end

    // map back through the quadrant
    always_comb
    begin
        case (q_reg[NS])
            2'd0:
            begin
                cos_next = hq_pkg::CS_W'(x_reg[NS]);
                sin_next = hq_pkg::CS_W'(y_reg[NS]);
            end
            2'd1:
            begin
                cos_next = hq_pkg::CS_W'(-y_reg[NS]);
                sin_next = hq_pkg::CS_W'(x_reg[NS]);
            end
            2'd2:
            begin
                cos_next = hq_pkg::CS_W'(-x_reg[NS]);
                sin_next = hq_pkg::CS_W'(-y_reg[NS]);
            end
            default:
            begin
                cos_next = hq_pkg::CS_W'(y_reg[NS]);
                sin_next = hq_pkg::CS_W'(-x_reg[NS]);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// File: hdl/hopf_to_quaternion.sv
// Hopf coordinates to unit quaternion.
// sample channel (sink): theta, phi, psi, unsigned turn fractions with
//   2^16 units per turn. A transaction completes when valid and ready are high.
// quat channel (source): quat_w, quat_x, quat_y, quat_z in Q1.15,
//   saturated at +/-32767. One result per sample, in order.
// Pipeline: the clock edge that accepts a sample loads the first of 19
//   register stages: 1 half-angle register, 16 CORDIC stages (quadrant
//   fold, 14 stages of two rotation steps, quadrant map), 1 multiply
//   register and 1 round/saturate output register. The 28 CORDIC steps
//   set that depth.
// Throughput: one sample per cycle while quat is not stalled; three CORDIC
//   pipelines run side by side.
// Stall: when quat.valid is high and quat.ready is low, the whole pipeline
//   holds and sample.ready drops; nothing is lost or repeated. An empty
//   output register lets the pipeline advance regardless of quat.ready.
// Reset: rst_n clears all valid bits asynchronously; no transaction is
//   pending afterward and sample.ready is high.
module hopf_to_quaternion (
    input  logic          clk,
    input  logic          rst_n,
    hq_sample_if.sink     sample,
    hq_quat_if.source     quat
);

    localparam int PL  = hq_pkg::PIPE_LEN;
    localparam int OB  = hq_pkg::OUT_BITS;
    localparam int PWD = hq_pkg::PROD_W;
    localparam int SH  = 61 - OB;
    localparam logic signed [PWD-1:0] ROUND_ADD = PWD'(1) <<< (SH - 1);
    localparam logic signed [PWD-1:0] LIM       = PWD'((1 << (OB - 1)) - 1);

    logic                 en;
    logic [PL-1:0]        valid_reg;
    logic [PL-1:0]        valid_next;

    hq_pkg::half_angle_t  theta_reg;
    hq_pkg::half_angle_t  psi_reg;
    hq_pkg::half_angle_t  fiber_reg;
    hq_pkg::half_angle_t  fiber_next;

    hq_pkg::trig_t        ct;
    hq_pkg::trig_t        st;
    hq_pkg::trig_t        cp;
    hq_pkg::trig_t        sp;
    hq_pkg::trig_t        cf;
    hq_pkg::trig_t        sf;

    logic signed [PWD-1:0] pw_reg;
    logic signed [PWD-1:0] px_reg;
    logic signed [PWD-1:0] py_reg;
    logic signed [PWD-1:0] pz_reg;
    logic signed [PWD-1:0] pw_next;
    logic signed [PWD-1:0] px_next;
    logic signed [PWD-1:0] py_next;
    logic signed [PWD-1:0] pz_next;

    hq_pkg::quat_part_t   qw_reg;
    hq_pkg::quat_part_t   qx_reg;
    hq_pkg::quat_part_t   qy_reg;
    hq_pkg::quat_part_t   qz_reg;

    // Q4.60 product to Q1.15: round half up, saturate symmetrically
    function automatic hq_pkg::quat_part_t scale_out(input logic signed [PWD-1:0] p);
        logic signed [PWD-1:0] r;
        r = (p + ROUND_ADD) >>> SH;
        if (r > LIM)
            r = LIM;
        if (r < -LIM)
            r = -LIM;
        return r[OB-1:0];
    endfunction

    // advance everything together unless a result waits on a stalled sink
    assign en           = !valid_reg[PL-1] || quat.ready;
    assign sample.ready = en;
    assign valid_next   = {valid_reg[PL-2:0], sample.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // half angles at one extra bit per turn: theta, psi, 2*phi + psi
    assign fiber_next = {sample.phi, 1'b0} + {1'b0, sample.psi};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg <= {1'b0, sample.theta};
            psi_reg   <= {1'b0, sample.psi};
            fiber_reg <= fiber_next;
        end
    end

    hq_cordic u_cordic_theta (
        .clk     (clk),
        .en      (en),
        .phase   (theta_reg),
        .cos_val (ct),
        .sin_val (st)
    );

    hq_cordic u_cordic_psi (
        .clk     (clk),
        .en      (en),
        .phase   (psi_reg),
        .cos_val (cp),
        .sin_val (sp)
    );

    hq_cordic u_cordic_fiber (
        .clk     (clk),
        .en      (en),
        .phase   (fiber_reg),
        .cos_val (cf),
        .sin_val (sf)
    );

    always_comb
    begin
        pw_next = ct * cp;
        px_next = ct * sp;
        py_next = st * cf;
        pz_next = st * sf;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_reg <= pw_next;
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            qw_reg <= scale_out(pw_reg);
            qx_reg <= scale_out(px_reg);
            qy_reg <= scale_out(py_reg);
            qz_reg <= scale_out(pz_reg);
        end
    end

    assign quat.valid  = valid_reg[PL-1];
    assign quat.quat_w = qw_reg;
    assign quat.quat_x = qx_reg;
    assign quat.quat_y = qy_reg;
    assign quat.quat_z = qz_reg;

endmodule
